>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cost accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BTCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/btca_pkg.sv
// ----------------------------------------------------------------------------
// btca_pkg
// Widths, codes and shared types of the bounded top-K cost accumulator.
// ----------------------------------------------------------------------------
package btca_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W   = 64;
    localparam int COST_W  = 40;
    localparam int SRC_W   = 32;
    localparam int TOTAL_W = 48;
    localparam int ROWS_W  = 16;
    localparam int STAMP_W = 32;
    localparam int LIMIT_W = 7;
    localparam int OUTC_W  = 2;
    localparam int CMP_W   = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX            = '1;
    localparam logic [ROWS_W-1:0]  ROWS_MAX             = '1;
    localparam logic [LIMIT_W-1:0] DISTINCT_LIMIT_RESET = LIMIT_W'(64);

    typedef enum logic [OUTC_W-1:0] {
        OUTCOME_ACCUM  = 2'd0,
        OUTCOME_INSERT = 2'd1,
        OUTCOME_EVICT  = 2'd2,
        OUTCOME_REJECT = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TOTAL_W-1:0] total;
        logic [ROWS_W-1:0]  rows;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic             clear;
        logic             rd_valid;
        logic [IDX_W-1:0] idx;
        logic             slot_valid;
    } t_scan_ctl;

    typedef struct packed {
        logic             hit_found;
        logic [IDX_W-1:0] hit_idx;
        t_entry           hit;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             vict_found;
        logic [IDX_W-1:0] vict_idx;
        t_entry           vict;
        logic [CNT_W-1:0] used;
    } t_scan_res;

endpackage

>>> rtl/core/btca_mem.sv
// ----------------------------------------------------------------------------
// btca_mem
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module btca_mem import btca_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/btca_scan.sv
// ----------------------------------------------------------------------------
// btca_scan
// Walks the table one entry per cycle and keeps the key match, the first
// free slot, the eviction candidate and the occupancy.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btca_scan import btca_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_scan_ctl          i_ctl,
    input  t_entry             i_entry,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [STAMP_W-1:0] i_clock,
    output t_scan_res          o_res
);

    t_scan_res          r_res;
    t_scan_res          n_res;
    logic [STAMP_W-1:0] age_new;
    logic [STAMP_W-1:0] age_vict;
    logic               take;

    always_comb begin
        age_new  = i_clock - i_entry.stamp;
        age_vict = i_clock - r_res.vict.stamp;
        take     = !r_res.vict_found
                || (i_entry.total < r_res.vict.total)
                || ((i_entry.total == r_res.vict.total) && (age_new > age_vict));
        n_res    = r_res;
        if (i_ctl.clear) begin
            n_res = '0;
        end else if (i_ctl.rd_valid) begin
            if (i_ctl.slot_valid) begin
                n_res.used = r_res.used + CNT_W'(1);
                if (!r_res.hit_found && (i_entry.key == i_key)) begin
                    n_res.hit_found = 1'b1;
                    n_res.hit_idx   = i_ctl.idx;
                    n_res.hit       = i_entry;
                end
                if (take) begin
                    n_res.vict_found = 1'b1;
                    n_res.vict_idx   = i_ctl.idx;
                    n_res.vict       = i_entry;
                end
            end else if (!r_res.free_found) begin
                n_res.free_found = 1'b1;
                n_res.free_idx   = i_ctl.idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

    `BTCA_ASSERT_NXT(a_hit_held, i_clk, i_rst_n, r_res.hit_found && !i_ctl.clear, r_res.hit_found && $stable(r_res.hit_idx), "Key match changed within one scan.")
    `BTCA_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_res.used <= CNT_W'(TABLE_DEPTH), "Occupancy count exceeds table depth.")

endmodule

>>> rtl/core/bounded_topk_cost_accumulator.sv
// ----------------------------------------------------------------------------
// bounded_topk_cost_accumulator
// Bounded table of distinct keys with accumulated cost, row counts and
// least-cost eviction, held in one entry memory.
// ----------------------------------------------------------------------------
// Transactions are handled one at a time: a new one is accepted only in the
// idle state, after the previous one has committed. Each scan reads all
// TABLE_DEPTH entries through the single read port of the entry memory.
// Reset clears all slot valid bits and the update clock at once, and sets the
// distinct limit to 64; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_topk_cost_accumulator import btca_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [KEY_W-1:0]   i_query_hash,
    input  logic [COST_W-1:0]  i_cost,
    input  logic [SRC_W-1:0]   i_source_id,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [OUTC_W-1:0]  o_outcome,
    output logic [ROWS_W-1:0]  o_contribution_index,
    output logic               o_index_saturated,
    output logic [TOTAL_W-1:0] o_total_cost,
    output logic [KEY_W-1:0]   o_evicted_hash,
    output logic [ROWS_W-1:0]  o_evicted_rows,
    output logic [SRC_W-1:0]   o_source_echo,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata
);

    t_state                 r_state;
    t_state                 n_state;
    logic [LIMIT_W-1:0]     r_limit;
    logic [KEY_W-1:0]       r_key;
    logic [COST_W-1:0]      r_cost;
    logic [SRC_W-1:0]       r_src;
    logic [STAMP_W-1:0]     r_clock;
    logic [TABLE_DEPTH-1:0] r_slot_valid;
    logic [IDX_W-1:0]       r_rd_idx;
    logic                   r_rd_pend;
    logic [IDX_W-1:0]       r_rd_pidx;
    logic                   r_rd_psv;

    logic                   r_out_valid;
    t_outcome               r_out_outcome;
    logic [ROWS_W-1:0]      r_out_index;
    logic                   r_out_sat;
    logic [TOTAL_W-1:0]     r_out_total;
    logic [KEY_W-1:0]       r_out_ev_key;
    logic [ROWS_W-1:0]      r_out_ev_rows;
    logic [SRC_W-1:0]       r_out_src;

    logic                   in_fire;
    logic                   out_free;
    logic                   scan_last;
    logic                   mem_re;
    logic                   mem_we;
    logic                   commit_fire;
    t_entry                 mem_rdata;
    t_scan_ctl              scan_ctl;
    t_scan_res              scan_res;

    logic [CMP_W-1:0]       eff_limit;
    logic                   room;
    logic [TOTAL_W:0]       sum;
    logic [TOTAL_W-1:0]     sat_total;
    logic                   rows_sat;
    logic [TOTAL_W-1:0]     cost_ext;
    t_outcome               c_outcome;
    logic [ROWS_W-1:0]      c_index;
    logic                   c_sat;
    logic [TOTAL_W-1:0]     c_total;
    logic [KEY_W-1:0]       c_ev_key;
    logic [ROWS_W-1:0]      c_ev_rows;
    logic                   c_we;
    logic                   c_set_valid;
    logic [IDX_W-1:0]       c_waddr;
    t_entry                 c_wdata;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign scan_last = (r_rd_idx == IDX_W'(TABLE_DEPTH - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        mem_re      = 1'b0;
        commit_fire = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_SCAN: begin
                mem_re = 1'b1;
            end
            ST_DRAIN: begin
                mem_re = 1'b0;
            end
            ST_COMMIT: begin
                commit_fire = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        mem_we = commit_fire && c_we;
    end

    always_comb begin
        eff_limit = CMP_W'(r_limit);
        if (eff_limit == '0) begin
            eff_limit = CMP_W'(1);
        end
        if (eff_limit > CMP_W'(TABLE_DEPTH)) begin
            eff_limit = CMP_W'(TABLE_DEPTH);
        end
        room      = (CMP_W'(scan_res.used) < eff_limit) && scan_res.free_found;
        cost_ext  = TOTAL_W'(r_cost);
        sum       = {1'b0, scan_res.hit.total} + (TOTAL_W + 1)'(r_cost);
        sat_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        rows_sat  = (scan_res.hit.rows == ROWS_MAX);

        c_outcome   = OUTCOME_REJECT;
        c_index     = '0;
        c_sat       = 1'b0;
        c_total     = '0;
        c_ev_key    = '0;
        c_ev_rows   = '0;
        c_we        = 1'b0;
        c_set_valid = 1'b0;
        c_waddr     = scan_res.vict_idx;
        c_wdata     = '{key: r_key, total: cost_ext, rows: ROWS_W'(1), stamp: r_clock};

        if (scan_res.hit_found) begin
            c_outcome     = OUTCOME_ACCUM;
            c_index       = scan_res.hit.rows;
            c_sat         = rows_sat;
            c_total       = sat_total;
            c_we          = 1'b1;
            c_waddr       = scan_res.hit_idx;
            c_wdata.total = sat_total;
            c_wdata.rows  = rows_sat ? scan_res.hit.rows
                                     : scan_res.hit.rows + ROWS_W'(1);
        end else if (room) begin
            c_outcome   = OUTCOME_INSERT;
            c_total     = cost_ext;
            c_we        = 1'b1;
            c_set_valid = 1'b1;
            c_waddr     = scan_res.free_idx;
        end else if (scan_res.vict_found && (scan_res.vict.total < cost_ext)) begin
            c_outcome = OUTCOME_EVICT;
            c_total   = cost_ext;
            c_ev_key  = scan_res.vict.key;
            c_ev_rows = scan_res.vict.rows;
            c_we      = 1'b1;
        end
    end

    always_comb begin
        scan_ctl.clear      = in_fire;
        scan_ctl.rd_valid   = r_rd_pend;
        scan_ctl.idx        = r_rd_pidx;
        scan_ctl.slot_valid = r_rd_psv;
    end

    btca_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd_idx),
        .o_rdata (mem_rdata)
    );

    btca_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_entry (mem_rdata),
        .i_key   (r_key),
        .i_clock (r_clock),
        .o_res   (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_limit      <= DISTINCT_LIMIT_RESET;
            r_clock      <= '0;
            r_slot_valid <= '0;
            r_rd_idx     <= '0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= mem_re;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_rd_idx <= '0;
            end else if (mem_re) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            if (mem_we) begin
                r_clock <= r_clock + STAMP_W'(1);
            end
            if (commit_fire && c_set_valid) begin
                r_slot_valid[c_waddr] <= 1'b1;
            end
            if (commit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_pidx <= r_rd_idx;
        r_rd_psv  <= r_slot_valid[r_rd_idx];
        if (in_fire) begin
            r_key  <= i_query_hash;
            r_cost <= i_cost;
            r_src  <= i_source_id;
        end
        if (commit_fire) begin
            r_out_outcome <= c_outcome;
            r_out_index   <= c_index;
            r_out_sat     <= c_sat;
            r_out_total   <= c_total;
            r_out_ev_key  <= c_ev_key;
            r_out_ev_rows <= c_ev_rows;
            r_out_src     <= r_src;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_outcome            = r_out_outcome;
    assign o_contribution_index = r_out_index;
    assign o_index_saturated    = r_out_sat;
    assign o_total_cost         = r_out_total;
    assign o_evicted_hash       = r_out_ev_key;
    assign o_evicted_rows       = r_out_ev_rows;
    assign o_source_echo        = r_out_src;

    `BTCA_ASSERT_IMP(a_insert_free, i_clk, i_rst_n, commit_fire && c_set_valid, !r_slot_valid[c_waddr], "Insert targets an occupied slot.")
    `BTCA_ASSERT_NXT(a_clock_step, i_clk, i_rst_n, mem_we, r_clock == $past(r_clock) + STAMP_W'(1), "Update clock did not advance on a table write.")
    `BTCA_ASSERT_NXT(a_reject_hold, i_clk, i_rst_n, commit_fire && !c_we, $stable(r_clock) && $stable(r_slot_valid), "Rejected transaction changed the table state.")

endmodule
